// ===== rtl/reversible_deque_engine_core_defines.svh =====
// assertion macros for the reversible deque engine rtl
// no dependencies; included by rde_back, which carries the concurrent checks
`ifndef REVERSIBLE_DEQUE_ENGINE_CORE_DEFINES_SVH
`define REVERSIBLE_DEQUE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RDE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rde check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RDE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rde check failed");

`endif

// ===== rtl/rde_pkg.sv =====
// shared types and constants for the reversible deque engine
// no dependencies; imported by every rde module
package rde_pkg;

    // default capacity of the element store
    localparam int RDE_DEPTH  = 64;
    // default depth of the command queue between front and back
    localparam int RDE_QDEPTH = 2;

    // transaction kind codes on the input port
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_REVERSE = 2'd1;
    localparam logic [1:0] KIND_DELETE  = 2'd2;
    localparam logic [1:0] KIND_DRAIN   = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_REVERSE = 2'd1,
        OP_DELETE  = 2'd2,
        OP_DRAIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_ELEMENT   = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_EMPTY_ERR = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } cmd_t;

endpackage

// ===== rtl/rde_front.sv =====
// front stage: accepts input transactions and decodes them into commands
// depends on rde_pkg
module rde_front
    import rde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] value,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        q_full
);

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t front_cmd_reg;
    cmd_t dec_cmd;
    logic take;

    assign in_stall = front_valid_reg && q_full;
    assign take     = in_valid && !in_stall;
    assign push     = front_valid_reg && !q_full;
    assign push_cmd = front_cmd_reg;

    // only loads carry a value downstream
    always_comb
    begin
        dec_cmd.value = '0;
        unique case (kind)
            KIND_LOAD:
            begin
                dec_cmd.op    = OP_LOAD;
                dec_cmd.value = value;
            end
            KIND_REVERSE: dec_cmd.op = OP_REVERSE;
            KIND_DELETE:  dec_cmd.op = OP_DELETE;
            KIND_DRAIN:   dec_cmd.op = OP_DRAIN;
            default:      dec_cmd.op = OP_DRAIN;
        endcase
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (take)
            front_valid_next = 1'b1;
        else if (push)
            front_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            front_cmd_reg <= dec_cmd;
    end

endmodule

// ===== rtl/rde_cmdq.sv =====
// short command queue decoupling the front stage from the back stage
// depends on rde_pkg
module rde_cmdq
    import rde_pkg::*;
#(
    parameter int QDEPTH = RDE_QDEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    cmd_t            slots_reg [QDEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CNTW'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTRW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTRW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNTW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/rde_back.sv =====
// back stage: element store, deque pointers, error flags and drain sequencer
// depends on rde_pkg and reversible_deque_engine_core_defines.svh
`include "reversible_deque_engine_core_defines.svh"

module rde_back
    import rde_pkg::*;
#(
    parameter int DEPTH = RDE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] element,
    output logic [1:0]  status,
    output logic        last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rev_reg;
    logic          rev_next;
    logic          err_reg;
    logic          err_next;
    logic          ovf_reg;
    logic          ovf_next;
    logic [PW-1:0] idx_reg;
    logic [PW-1:0] idx_next;
    logic          rd_pend_reg;
    logic          rd_pend_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic          rd_last_reg;
    logic [31:0]   element_reg;
    status_t       status_reg;
    logic          last_reg;

    logic          out_free;
    logic          is_drain;
    logic          drain_status;
    logic          emit_status;
    logic          issue;
    logic          idx_last;
    logic          wr_en;
    logic [PW-1:0] wr_slot;
    logic [PW-1:0] rd_slot;
    logic [PW-1:0] head_inc;
    logic [CW-1:0] rd_off;

    function automatic logic [PW-1:0] wrap_slot(input logic [PW:0] s);
        logic [PW:0] d;
        d = s - (PW+1)'(DEPTH);
        return (s >= (PW+1)'(DEPTH)) ? d[PW-1:0] : s[PW-1:0];
    endfunction

    assign out_free     = !out_valid_reg || !out_stall;
    assign is_drain     = (q_cmd.op == OP_DRAIN);
    assign drain_status = err_reg || ovf_reg || (count_reg == '0);

    // status drains need the output register and no element still in flight
    assign pop = q_valid && (state_reg == ST_RUN)
                 && (!is_drain || !drain_status || (!rd_pend_reg && out_free));
    assign emit_status = pop && is_drain && drain_status;

    assign issue    = (state_reg == ST_DRAIN) && (!rd_pend_reg || out_free);
    assign idx_last = (CW'(idx_reg) + CW'(1)) == count_reg;

    assign wr_en    = pop && (q_cmd.op == OP_LOAD) && (count_reg < FULL);
    assign wr_slot  = wrap_slot({1'b0, head_reg} + {1'b0, count_reg[PW-1:0]});
    assign head_inc = wrap_slot({1'b0, head_reg} + (PW+1)'(1));
    assign rd_off   = rev_reg ? (count_reg - CW'(1) - CW'(idx_reg)) : CW'(idx_reg);
    assign rd_slot  = wrap_slot({1'b0, head_reg} + {1'b0, rd_off[PW-1:0]});

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        err_next   = err_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;

        if (pop)
        begin
            unique case (q_cmd.op)
                OP_LOAD:
                begin
                    if (count_reg < FULL)
                        count_next = count_reg + CW'(1);
                    else
                        ovf_next = 1'b1;
                end
                OP_REVERSE: rev_next = !rev_reg;
                OP_DELETE:
                begin
                    if (count_reg == '0)
                        err_next = 1'b1;
                    else
                    begin
                        if (!rev_reg)
                            head_next = head_inc;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_DRAIN:
                begin
                    if (drain_status)
                    begin
                        head_next  = '0;
                        count_next = '0;
                        rev_next   = 1'b0;
                        err_next   = 1'b0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                        idx_next   = '0;
                    end
                end
                default: ;
            endcase
        end

        if (issue)
        begin
            idx_next = idx_reg + PW'(1);
            if (idx_last)
            begin
                state_next = ST_RUN;
                head_next  = '0;
                count_next = '0;
                rev_next   = 1'b0;
                err_next   = 1'b0;
                ovf_next   = 1'b0;
            end
        end

        rd_pend_next   = issue || (rd_pend_reg && !out_free);
        out_valid_next = (rd_pend_reg && out_free) || emit_status
                         || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            err_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            err_reg       <= err_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // element store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_slot] <= q_cmd.value;
        if (issue)
        begin
            rd_data_reg <= mem[rd_slot];
            rd_last_reg <= idx_last;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg && out_free)
        begin
            element_reg <= rd_data_reg;
            status_reg  <= STAT_ELEMENT;
            last_reg    <= rd_last_reg;
        end
        else if (emit_status)
        begin
            element_reg <= '0;
            last_reg    <= 1'b1;
            if (err_reg)
                status_reg <= STAT_EMPTY_ERR;
            else if (ovf_reg)
                status_reg <= STAT_OVERFLOW;
            else
                status_reg <= STAT_EMPTY;
        end
    end

    assign out_valid = out_valid_reg;
    assign element   = element_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    `RDE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FULL)
    `RDE_ASSERT_IMP(a_drain_index, state_reg == ST_DRAIN, CW'(idx_reg) < count_reg)
    `RDE_ASSERT_NXT(a_drain_clears, issue && idx_last, count_reg == '0 && !rev_reg && !err_reg)
    `RDE_ASSERT_NXT(a_pend_holds, rd_pend_reg && !out_free, rd_pend_reg && $stable(rd_data_reg))

endmodule

// ===== rtl/reversible_deque_engine_core.sv =====
// reversible deque engine: bounded double-ended queue with a direction bit
// top level; depends on rde_pkg, rde_front, rde_cmdq and rde_back
//
// Load, reverse and delete transactions are taken one per clock while the
// command queue has room and retire in the back stage; they produce no
// output. A drain of N stored elements produces N output transactions at one
// per cycle while out_stall is low, the rate being set by the single read
// port of the element store, with the final one flagged by last. A drain
// with a latched delete-on-empty error, a latched overflow, or an empty queue
// produces a single status transaction instead (the empty error wins over the
// overflow). Every drain clears the queue, the direction bit and both error
// flags. While a drain of elements runs, later transactions wait in the front
// stage and the command queue. From input acceptance, a drain passes the
// front register, command queue, store read and output register before its
// first output. The element store has no reset and needs no clearing pass.
module reversible_deque_engine_core
    import rde_pkg::*;
#(
    parameter int DEPTH  = RDE_DEPTH,
    parameter int QDEPTH = RDE_QDEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] value,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] element,
    output logic [1:0]  status,
    output logic        last
);

    // front to queue
    logic push;
    cmd_t push_cmd;
    logic q_full;

    // queue to back
    logic q_valid;
    cmd_t q_cmd;
    logic pop;

    // decode stage, stalls only when the queue is full
    rde_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .value    (value),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // short queue so the front keeps taking transactions while the back drains
    rde_cmdq #(
        .QDEPTH (QDEPTH)
    ) u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    // store, pointers, flags and the drain sequencer with its output register
    rde_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .element   (element),
        .status    (status),
        .last      (last)
    );

endmodule

// ===== test/rde_drain_checker.sv =====
// drain checker for the reversible deque engine: watches both channels,
// predicts every drain and compares it with what the block sends out
// depends on rde_pkg
module rde_drain_checker
    import rde_pkg::*;
#(
    parameter int DEPTH = RDE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] element,
    input  logic [1:0]  status,
    input  logic        last,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0] element;
        status_t     status;
        logic        last;
    } drain_word_t;

    // shadow copy of the deque
    logic [31:0] slots [DEPTH];
    int          head;
    int          count;
    logic        reversed;
    logic        empty_err;
    logic        overflow;

    drain_word_t drain_q [$];

    task push_word(input logic [31:0] e, input status_t s, input logic l);
        drain_word_t w;
        w.element = e;
        w.status  = s;
        w.last    = l;
        drain_q.insert(drain_q.size(), w);
    endtask

    task apply_transaction(input op_t op, input logic [31:0] v);
        int i;
        int off;
        case (op)
            OP_LOAD:
            begin
                if (count < DEPTH)
                begin
                    slots[(head + count) % DEPTH] = v;
                    count++;
                end
                else
                    overflow = 1'b1;
            end
            OP_REVERSE:
                reversed = ~reversed;
            OP_DELETE:
            begin
                if (count == 0)
                    empty_err = 1'b1;
                else
                begin
                    // reversed: the front is the last stored slot, head stays
                    if (!reversed)
                        head = (head + 1) % DEPTH;
                    count--;
                end
            end
            default:
            begin
                if (empty_err)
                    push_word('0, STAT_EMPTY_ERR, 1'b1);
                else if (overflow)
                    push_word('0, STAT_OVERFLOW, 1'b1);
                else if (count == 0)
                    push_word('0, STAT_EMPTY, 1'b1);
                else
                begin
                    for (i = 0; i < count; i++)
                    begin
                        off = reversed ? (count - 1 - i) : i;
                        push_word(slots[(head + off) % DEPTH], STAT_ELEMENT, i == count - 1);
                    end
                end
                head      = 0;
                count     = 0;
                reversed  = 1'b0;
                empty_err = 1'b0;
                overflow  = 1'b0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        drain_word_t want;
        if (!rst_n)
        begin
            head       = 0;
            count      = 0;
            reversed   = 1'b0;
            empty_err  = 1'b0;
            overflow   = 1'b0;
            mismatches = 0;
            drain_q.delete();
        end
        else
        begin
            // compare before predicting so a new drain never matches its own cycle
            if (out_valid && !out_stall)
            begin
                if (drain_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual element %h status %0d last %b",
                             $time, element, status, last);
                    mismatches++;
                end
                else
                begin
                    want = drain_q[0];
                    drain_q.delete(0);
                    if (element !== want.element)
                    begin
                        $display("%0t: element mismatch, expected %h, actual %h",
                                 $time, want.element, element);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, status);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %b, actual %b",
                                 $time, want.last, last);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_transaction(op_t'(kind), value);
        end
        outstanding = drain_q.size();
    end

endmodule

// ===== test/reversible_deque_engine_core_tb.sv =====
// testbench top for reversible_deque_engine_core: clock, reset, stimulus and verdict
// depends on rde_pkg, rde_drain_checker and the rtl of the block
module reversible_deque_engine_core_tb;
    import rde_pkg::*;

    localparam int CAP         = RDE_DEPTH;
    localparam int ITEM_TARGET = 470;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] element;
    logic [1:0]  status;
    logic        last;

    int          mismatches;
    int          outstanding;

    // pacing controls for the sender and the receiver
    logic        tx_calm;
    logic        rx_calm;
    logic        hold_req;
    int          items_sent;

    reversible_deque_engine_core #(
        .DEPTH (CAP)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .element   (element),
        .status    (status),
        .last      (last)
    );

    rde_drain_checker #(
        .DEPTH (CAP)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element     (element),
        .status      (status),
        .last        (last),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // random words half the time, the sign and all-ones/all-zeros corners otherwise
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // one input transaction: optional gap, then hold the payload until taken
    // entered and left at a falling edge
    task automatic send_item(input logic [1:0] k, input logic [31:0] v);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind     = k;
        value    = v;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic load(input logic [31:0] v);
        send_item(KIND_LOAD, v);
    endtask

    task automatic drain();
        send_item(KIND_DRAIN, $urandom);
    endtask

    // sender pause until the checker holds no expected result
    task automatic wait_idle();
        if (in_valid)
            in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // back-to-back loads, the odd reverse or delete thrown in when asked
    task automatic fill_store(input int n, input bit mixed);
        int i;
        int sel;
        for (i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (mixed && sel < 5)
                send_item(KIND_REVERSE, $urandom);
            else if (mixed && sel < 10)
                send_item(KIND_DELETE, $urandom);
            else
                load(pick_value());
        end
    endtask

    // one random round: a short burst of operations closed by a drain most of
    // the time; now and then a near-full or overflowing burst instead
    task automatic queue_round();
        int n;
        int i;
        int sel;
        tx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 24) == 0)
            fill_store($urandom_range(CAP - 4, CAP + 2), 1'b1);
        else
        begin
            n = $urandom_range(0, 10);
            for (i = 0; i < n; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 62)
                    load(pick_value());
                else if (sel < 77)
                    send_item(KIND_REVERSE, $urandom);
                else if (sel < 95)
                    send_item(KIND_DELETE, $urandom);
                else
                    send_item(2'($urandom_range(0, 3)), $urandom);
            end
        end
        // leave the odd round open so its contents carry into the next one
        if ($urandom_range(0, 9) != 0)
            drain();
        if ($urandom_range(0, 11) == 0)
            wait_idle();
    endtask

    // receiver: a random stall before every result, calm stretches now and
    // then, and one long hold-off when the sender asks for it
    initial
    begin : receiver
        int k;
        int taken;
        bit held;
        out_stall = 1'b0;
        rx_calm   = 1'b0;
        taken     = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                held      = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (taken % 32 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            k = rx_calm ? 0 : $urandom_range(0, 9);
            if (k > 0)
            begin
                out_stall = 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // watchdog: ends the run when neither channel moves for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[reversible_deque_engine_core] ERROR");
        $finish;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_LOAD;
        value      = '0;
        tx_calm    = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // drain of an empty queue after reset
        drain();
        // value corners in stored order
        load(32'h7fff_ffff);
        load(32'h8000_0000);
        load(32'h0000_0000);
        load(32'hffff_ffff);
        load(32'h5a5a_a5a5);
        drain();
        // reversed drain
        load(32'd1);
        load(32'd2);
        load(32'd3);
        send_item(KIND_REVERSE, '0);
        drain();
        // delete from the front, then from the back once reversed
        load(32'd10);
        load(32'd20);
        load(32'd30);
        send_item(KIND_DELETE, '0);
        send_item(KIND_REVERSE, '0);
        send_item(KIND_DELETE, '0);
        drain();
        // repeated delete on empty collapses to one error, sent instead of the contents
        send_item(KIND_DELETE, '0);
        send_item(KIND_DELETE, '0);
        load(32'd7);
        drain();
        // direction only, still an empty drain; the drain clears it again
        send_item(KIND_REVERSE, '0);
        drain();

        // full store drained reversed while the receiver holds off; the
        // sender keeps offering the next rounds so the input backs up
        wait_idle();
        tx_calm = 1'b1;
        fill_store(CAP, 1'b0);
        send_item(KIND_REVERSE, '0);
        hold_req = 1'b1;
        drain();
        // error on empty together with an overflow: the error wins
        send_item(KIND_DELETE, '0);
        fill_store(CAP + 1, 1'b0);
        drain();
        // overflow alone
        fill_store(CAP + 2, 1'b0);
        drain();
        wait_idle();
        tx_calm = 1'b0;

        while (items_sent < ITEM_TARGET)
            queue_round();
        drain();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[reversible_deque_engine_core] OK");
        else
            $display("[reversible_deque_engine_core] ERROR");
        $finish;
    end

endmodule
